// ===== hw/rtl/shsd_pkg.sv =====
// shared types, opcodes and the half-step coil table for the stepper driver
`timescale 1ns / 1ps

package shsd_pkg;

	// half-step sequence length
	localparam int unsigned PHASE_COUNT = 8;

	// event opcodes carried by each input item
	typedef enum logic [2:0] {
		OP_TICK    = 3'd0,
		OP_TOGGLE  = 3'd1,
		OP_FORWARD = 3'd2,
		OP_SLOWER  = 3'd3,
		OP_FASTER  = 3'd4,
		OP_SERVICE = 3'd5
	} opcode_t;

	// direction codes
	localparam logic [1:0] DIR_STOP    = 2'd0;
	localparam logic [1:0] DIR_REVERSE = 2'd1;
	localparam logic [1:0] DIR_FORWARD = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_PERIOD_BASE   = 3'd0;
	localparam logic [2:0] REG_PERIOD_SCALE  = 3'd1;
	localparam logic [2:0] REG_SPEED_STEP    = 3'd2;
	localparam logic [2:0] REG_SPEED_CEILING = 3'd3;
	localparam logic [2:0] REG_SPEED_FLOOR   = 3'd4;
	localparam logic [2:0] REG_ENCODER_LOW   = 3'd5;
	localparam logic [2:0] REG_ENCODER_HIGH  = 3'd6;
	localparam logic [2:0] REG_DUTY_SCALE    = 3'd7;

	// register reset values
	localparam logic [15:0] PERIOD_BASE_RST   = 16'd2000;
	localparam logic [7:0]  PERIOD_SCALE_RST  = 8'd10;
	localparam logic [7:0]  SPEED_STEP_RST    = 8'd10;
	localparam logic [7:0]  SPEED_CEILING_RST = 8'd190;
	localparam logic [7:0]  SPEED_FLOOR_RST   = 8'd10;
	localparam logic [7:0]  ENCODER_LOW_RST   = 8'd1;
	localparam logic [7:0]  ENCODER_HIGH_RST  = 8'd10;
	localparam logic [7:0]  DUTY_SCALE_RST    = 8'd10;

	// input item
	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] encoder_count;
	} cmd_t;

	// result item
	typedef struct packed {
		logic [3:0]  coil_pattern;
		logic        coil_write;
		logic [15:0] timer_period;
		logic        period_write;
		logic [7:0]  pwm_compare;
		logic [7:0]  encoder_writeback;
		logic [7:0]  speed_now;
		logic [1:0]  direction_now;
		logic [2:0]  phase_now;
	} res_t;

	// half-step coil drive table
	function automatic logic [3:0] half_step(input logic [2:0] idx);
		logic [3:0] pat;
		case (idx)
			3'd0: pat = 4'b0011;
			3'd1: pat = 4'b0010;
			3'd2: pat = 4'b0110;
			3'd3: pat = 4'b0100;
			3'd4: pat = 4'b1100;
			3'd5: pat = 4'b1000;
			3'd6: pat = 4'b1001;
			3'd7: pat = 4'b0001;
			default: pat = 4'b0000;
		endcase
		return pat;
	endfunction

endpackage

// ===== hw/rtl/stepper_half_step_driver.sv =====
// event-driven half-step stepper driver: input register, update logic, result register
//
//  channel  | signals                          | dir | notes
//  ---------+----------------------------------+-----+----------------------------
//  command  | cmd_valid, cmd_ready, cmd        | in  | one event item
//  result   | res_valid, res_ready, res        | out | one result per event item
//  config   | cfg_we, cfg_index, cfg_wdata     | in  | write only, no wait
//
// one item per cycle sustained while results are taken; an accepted item passes the input register,
// then the result register, which holds the updated motor state.
// arst_n clears the motor state and loads the register defaults.
// a stalled result holds the update stage; the input register still takes an item
// when the update stage moves on in the same cycle.
`timescale 1ns / 1ps

module stepper_half_step_driver (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  shsd_pkg::cmd_t      cmd,
	output logic                res_valid,
	input  logic                res_ready,
	output shsd_pkg::res_t      res,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_wdata
);

	// configuration registers
	logic [15:0] period_base_q;
	logic [7:0]  period_scale_q, speed_step_q, speed_ceiling_q, speed_floor_q;
	logic [7:0]  encoder_low_q, encoder_high_q, duty_scale_q;

	// motor state
	logic [2:0]  phase_q;
	logic [1:0]  direction_q;
	logic [7:0]  speed_q;
	logic [7:0]  pwm_q;
	logic [3:0]  coil_q;
	logic [15:0] period_q;

	// pipeline
	logic             valid_s1;
	shsd_pkg::cmd_t   cmd_s1;
	logic             res_valid_q;
	shsd_pkg::res_t   res_q;
	logic             advance;

	// next state and result
	logic [2:0]  phase_d;
	logic [1:0]  direction_d;
	logic [7:0]  speed_d;
	logic [7:0]  pwm_d;
	logic [3:0]  coil_d;
	logic [15:0] period_d;
	logic        coil_wr;
	logic        period_wr;
	logic [7:0]  clamped;
	logic [7:0]  writeback;
	logic [15:0] duty_prod;
	logic [15:0] reduction;
	logic [8:0]  speed_sum;

	assign advance   = valid_s1 && (!res_valid_q || res_ready);
	assign cmd_ready = !valid_s1 || advance;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_base_q   <= shsd_pkg::PERIOD_BASE_RST;
			period_scale_q  <= shsd_pkg::PERIOD_SCALE_RST;
			speed_step_q    <= shsd_pkg::SPEED_STEP_RST;
			speed_ceiling_q <= shsd_pkg::SPEED_CEILING_RST;
			speed_floor_q   <= shsd_pkg::SPEED_FLOOR_RST;
			encoder_low_q   <= shsd_pkg::ENCODER_LOW_RST;
			encoder_high_q  <= shsd_pkg::ENCODER_HIGH_RST;
			duty_scale_q    <= shsd_pkg::DUTY_SCALE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				shsd_pkg::REG_PERIOD_BASE:   period_base_q   <= cfg_wdata;
				shsd_pkg::REG_PERIOD_SCALE:  period_scale_q  <= cfg_wdata[7:0];
				shsd_pkg::REG_SPEED_STEP:    speed_step_q    <= cfg_wdata[7:0];
				shsd_pkg::REG_SPEED_CEILING: speed_ceiling_q <= cfg_wdata[7:0];
				shsd_pkg::REG_SPEED_FLOOR:   speed_floor_q   <= cfg_wdata[7:0];
				shsd_pkg::REG_ENCODER_LOW:   encoder_low_q   <= cfg_wdata[7:0];
				shsd_pkg::REG_ENCODER_HIGH:  encoder_high_q  <= cfg_wdata[7:0];
				shsd_pkg::REG_DUTY_SCALE:    duty_scale_q    <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_s1 <= cmd;
		end
	end

	// shared arithmetic for speed and service events
	always_comb begin
		if (cmd_s1.encoder_count > encoder_high_q) begin
			clamped = encoder_high_q;
		end else if (cmd_s1.encoder_count < encoder_low_q) begin
			clamped = encoder_low_q;
		end else begin
			clamped = cmd_s1.encoder_count;
		end
		duty_prod = 16'(clamped) * 16'(duty_scale_q);
		reduction = 16'(speed_q) * 16'(period_scale_q);
		speed_sum = 9'(speed_q) + 9'(speed_step_q);
	end

	// state update per opcode
	always_comb begin
		phase_d     = phase_q;
		direction_d = direction_q;
		speed_d     = speed_q;
		pwm_d       = pwm_q;
		coil_d      = coil_q;
		period_d    = period_q;
		coil_wr     = 1'b0;
		period_wr   = 1'b0;
		writeback   = 8'd0;
		case (cmd_s1.opcode)
			shsd_pkg::OP_TICK: begin
				phase_d = phase_q + 3'd1;
			end
			shsd_pkg::OP_TOGGLE: begin
				direction_d = (direction_q == shsd_pkg::DIR_STOP) ?
					shsd_pkg::DIR_REVERSE : shsd_pkg::DIR_STOP;
			end
			shsd_pkg::OP_FORWARD: begin
				direction_d = shsd_pkg::DIR_FORWARD;
			end
			shsd_pkg::OP_SLOWER: begin
				if (speed_q >= speed_floor_q) begin
					speed_d = (speed_q >= speed_step_q) ? speed_q - speed_step_q : 8'd0;
				end
			end
			shsd_pkg::OP_FASTER: begin
				if (speed_q <= speed_ceiling_q) begin
					speed_d = speed_sum[8] ? 8'hFF : speed_sum[7:0];
				end
			end
			shsd_pkg::OP_SERVICE: begin
				writeback = clamped;
				pwm_d     = (duty_prod > 16'd255) ? 8'hFF : duty_prod[7:0];
				if (speed_q != 8'd0 || direction_q != shsd_pkg::DIR_STOP) begin
					period_d  = (reduction >= period_base_q) ? 16'd0 :
						period_base_q - reduction;
					period_wr = 1'b1;
					if (direction_q == shsd_pkg::DIR_REVERSE) begin
						// reverse walk, index wraps at phase zero
						coil_d  = shsd_pkg::half_step(3'd0 - phase_q);
						coil_wr = 1'b1;
					end else if (direction_q == shsd_pkg::DIR_FORWARD) begin
						coil_d  = shsd_pkg::half_step(phase_q);
						coil_wr = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// motor state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 3'd0;
			direction_q <= shsd_pkg::DIR_STOP;
			speed_q     <= 8'd0;
			pwm_q       <= 8'd0;
			coil_q      <= 4'd0;
			period_q    <= 16'd0;
		end else if (advance) begin
			phase_q     <= phase_d;
			direction_q <= direction_d;
			speed_q     <= speed_d;
			pwm_q       <= pwm_d;
			coil_q      <= coil_d;
			period_q    <= period_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.coil_pattern      <= coil_d;
			res_q.coil_write        <= coil_wr;
			res_q.timer_period      <= period_d;
			res_q.period_write      <= period_wr;
			res_q.pwm_compare       <= pwm_d;
			res_q.encoder_writeback <= writeback;
			res_q.speed_now         <= speed_d;
			res_q.direction_now     <= direction_d;
			res_q.phase_now         <= phase_d;
		end
	end

	// direction never reaches the unused code
	a_dir_legal: assert property (@(posedge clk) disable iff (!arst_n)
		direction_q != 2'd3)
		else $error("direction register holds unused code");

	// a coil write only comes with a period write
	a_coil_period: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.coil_write |-> res_q.period_write)
		else $error("coil write without period write");

	// a period write needs a moving motor
	a_period_active: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.period_write |->
			(res_q.speed_now != 8'd0 || res_q.direction_now != shsd_pkg::DIR_STOP))
		else $error("period write while motor stopped");

	// an empty result register never blocks the input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid_q |-> cmd_ready)
		else $error("input blocked with empty result register");

endmodule

// ===== tb/tb_stepper_half_step_driver.sv =====
// self-checking testbench for the half-step stepper driver, with its own motor model and random traffic
`timescale 1ns / 1ps

module tb_stepper_half_step_driver;

	// opcodes outside the defined set, which the block must ignore
	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;

	// half-step coil sequence, entry 0 in the low nibble
	localparam logic [31:0] COIL_SEQ = {4'b0001, 4'b1001, 4'b1000, 4'b1100,
		4'b0100, 4'b0110, 4'b0010, 4'b0011};

	localparam int RANDOM_ITEMS = 153;
	localparam int MAX_PRINTED  = 100;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            cmd_valid = 1'b0;
	logic            cmd_ready;
	shsd_pkg::cmd_t  cmd = '0;
	logic            res_valid;
	logic            res_ready = 1'b0;
	shsd_pkg::res_t  res;
	logic            cfg_we = 1'b0;
	logic [2:0]      cfg_index = '0;
	logic [15:0]     cfg_wdata = '0;

	// model of the configuration registers
	logic [15:0] cfg_period_base;
	logic [7:0]  cfg_period_scale, cfg_speed_step, cfg_speed_ceiling, cfg_speed_floor;
	logic [7:0]  cfg_encoder_low, cfg_encoder_high, cfg_duty_scale;

	// model of the motor state
	logic [2:0]  mot_phase;
	logic [1:0]  mot_dir;
	logic [7:0]  mot_speed, mot_pwm;
	logic [3:0]  mot_coil;
	logic [15:0] mot_period;

	shsd_pkg::res_t pending_results[$];
	int   error_count = 0;
	int   burst_left = 0;

	stepper_half_step_driver DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	// give up long after the slowest correct run would have finished
	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		if (error_count < MAX_PRINTED)
			$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	task automatic check_field(input string what, input int unsigned got,
		input int unsigned want);
		if (got != want)
			report_mismatch(what, got, want);
	endtask

	task automatic reset_motor_model();
		cfg_period_base   = shsd_pkg::PERIOD_BASE_RST;
		cfg_period_scale  = shsd_pkg::PERIOD_SCALE_RST;
		cfg_speed_step    = shsd_pkg::SPEED_STEP_RST;
		cfg_speed_ceiling = shsd_pkg::SPEED_CEILING_RST;
		cfg_speed_floor   = shsd_pkg::SPEED_FLOOR_RST;
		cfg_encoder_low   = shsd_pkg::ENCODER_LOW_RST;
		cfg_encoder_high  = shsd_pkg::ENCODER_HIGH_RST;
		cfg_duty_scale    = shsd_pkg::DUTY_SCALE_RST;
		mot_phase  = '0;
		mot_dir    = shsd_pkg::DIR_STOP;
		mot_speed  = '0;
		mot_pwm    = '0;
		mot_coil   = '0;
		mot_period = '0;
	endtask

	// apply one event to the motor model and give the result it should produce
	function automatic shsd_pkg::res_t advance_motor(input shsd_pkg::cmd_t c);
		shsd_pkg::res_t r;
		int unsigned clamped, product, reduction, sum, idx;
		r = '0;
		case (c.opcode)
			shsd_pkg::OP_TICK: begin
				mot_phase = 3'((mot_phase + 1) % shsd_pkg::PHASE_COUNT);
			end
			shsd_pkg::OP_TOGGLE: begin
				mot_dir = (mot_dir == shsd_pkg::DIR_STOP) ? shsd_pkg::DIR_REVERSE :
					shsd_pkg::DIR_STOP;
			end
			shsd_pkg::OP_FORWARD: begin
				mot_dir = shsd_pkg::DIR_FORWARD;
			end
			shsd_pkg::OP_SLOWER: begin
				if (mot_speed >= cfg_speed_floor)
					mot_speed = (mot_speed >= cfg_speed_step) ? mot_speed - cfg_speed_step : 8'd0;
			end
			shsd_pkg::OP_FASTER: begin
				if (mot_speed <= cfg_speed_ceiling) begin
					sum = mot_speed + cfg_speed_step;
					mot_speed = (sum > 255) ? 8'd255 : 8'(sum);
				end
			end
			shsd_pkg::OP_SERVICE: begin
				// upper clamp wins when the limits are crossed
				clamped = c.encoder_count;
				if (clamped > cfg_encoder_high)
					clamped = cfg_encoder_high;
				else if (clamped < cfg_encoder_low)
					clamped = cfg_encoder_low;
				r.encoder_writeback = 8'(clamped);
				product = clamped * cfg_duty_scale;
				mot_pwm = (product > 255) ? 8'd255 : 8'(product);
				if (mot_speed != 0 || mot_dir != shsd_pkg::DIR_STOP) begin
					reduction = mot_speed * cfg_period_scale;
					mot_period = (reduction >= cfg_period_base) ? 16'd0 :
						16'(cfg_period_base - reduction);
					r.period_write = 1'b1;
					// reverse walk wraps the index at phase zero
					if (mot_dir == shsd_pkg::DIR_REVERSE) begin
						idx = (shsd_pkg::PHASE_COUNT - mot_phase) % shsd_pkg::PHASE_COUNT;
						mot_coil = COIL_SEQ[idx * 4 +: 4];
						r.coil_write = 1'b1;
					end else if (mot_dir == shsd_pkg::DIR_FORWARD) begin
						idx = mot_phase;
						mot_coil = COIL_SEQ[idx * 4 +: 4];
						r.coil_write = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		r.coil_pattern  = mot_coil;
		r.timer_period  = mot_period;
		r.pwm_compare   = mot_pwm;
		r.speed_now     = mot_speed;
		r.direction_now = mot_dir;
		r.phase_now     = mot_phase;
		return r;
	endfunction

	// send one item, then maybe pause at the end of a burst
	task automatic send_cmd(input logic [2:0] op, input logic [7:0] enc);
		shsd_pkg::cmd_t c;
		int gap;
		c.opcode = op;
		c.encoder_count = enc;
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		pending_results.push_back(advance_motor(c));
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// hold off the sender until every result is back
	task automatic drain_results();
		cmd_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			shsd_pkg::REG_PERIOD_BASE:   cfg_period_base   = val;
			shsd_pkg::REG_PERIOD_SCALE:  cfg_period_scale  = val[7:0];
			shsd_pkg::REG_SPEED_STEP:    cfg_speed_step    = val[7:0];
			shsd_pkg::REG_SPEED_CEILING: cfg_speed_ceiling = val[7:0];
			shsd_pkg::REG_SPEED_FLOOR:   cfg_speed_floor   = val[7:0];
			shsd_pkg::REG_ENCODER_LOW:   cfg_encoder_low   = val[7:0];
			shsd_pkg::REG_ENCODER_HIGH:  cfg_encoder_high  = val[7:0];
			shsd_pkg::REG_DUTY_SCALE:    cfg_duty_scale    = val[7:0];
			default: begin
			end
		endcase
	endtask

	// the block must be idle before any register changes
	task automatic load_config(input logic [15:0] base, input logic [7:0] scale,
		input logic [7:0] step, input logic [7:0] ceiling, input logic [7:0] floor,
		input logic [7:0] enc_lo, input logic [7:0] enc_hi, input logic [7:0] duty);
		drain_results();
		write_reg(shsd_pkg::REG_PERIOD_BASE, base);
		write_reg(shsd_pkg::REG_PERIOD_SCALE, {8'd0, scale});
		write_reg(shsd_pkg::REG_SPEED_STEP, {8'd0, step});
		write_reg(shsd_pkg::REG_SPEED_CEILING, {8'd0, ceiling});
		write_reg(shsd_pkg::REG_SPEED_FLOOR, {8'd0, floor});
		write_reg(shsd_pkg::REG_ENCODER_LOW, {8'd0, enc_lo});
		write_reg(shsd_pkg::REG_ENCODER_HIGH, {8'd0, enc_hi});
		write_reg(shsd_pkg::REG_DUTY_SCALE, {8'd0, duty});
	endtask

	// mostly ticks, speed buttons and service calls, with a few ignored opcodes
	task automatic run_random_events(input int count);
		int pick;
		logic [2:0] op;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 30)
				op = shsd_pkg::OP_TICK;
			else if (pick < 38)
				op = shsd_pkg::OP_TOGGLE;
			else if (pick < 46)
				op = shsd_pkg::OP_FORWARD;
			else if (pick < 58)
				op = shsd_pkg::OP_SLOWER;
			else if (pick < 73)
				op = shsd_pkg::OP_FASTER;
			else if (pick < 97)
				op = shsd_pkg::OP_SERVICE;
			else if (pick < 98)
				op = OP_SPARE_A;
			else
				op = OP_SPARE_B;
			send_cmd(op, 8'($urandom_range(0, 255)));
		end
	endtask

	// directed events at the reset settings
	task automatic test_reset_defaults();
		// encoder extremes with the motor stopped: no period or coil write
		send_cmd(shsd_pkg::OP_SERVICE, 8'd0);
		send_cmd(shsd_pkg::OP_SERVICE, 8'd255);
		// phase wraps back to zero
		repeat (8) send_cmd(shsd_pkg::OP_TICK, 8'd0);
		// reverse walk at phase zero, then one step on
		send_cmd(shsd_pkg::OP_TOGGLE, 8'd0);
		send_cmd(shsd_pkg::OP_SERVICE, 8'd5);
		send_cmd(shsd_pkg::OP_TICK, 8'd0);
		send_cmd(shsd_pkg::OP_SERVICE, 8'd7);
		// forward walk, then toggle from forward to stopped
		send_cmd(shsd_pkg::OP_FORWARD, 8'd0);
		send_cmd(shsd_pkg::OP_SERVICE, 8'd3);
		send_cmd(shsd_pkg::OP_TOGGLE, 8'd0);
		send_cmd(shsd_pkg::OP_SERVICE, 8'd9);
		// slower below the floor does nothing; speed alone enables the period
		send_cmd(shsd_pkg::OP_SLOWER, 8'd0);
		send_cmd(shsd_pkg::OP_FASTER, 8'd0);
		send_cmd(shsd_pkg::OP_FASTER, 8'd0);
		send_cmd(shsd_pkg::OP_SERVICE, 8'd10);
		// ignored opcodes
		send_cmd(OP_SPARE_A, 8'hAA);
		send_cmd(OP_SPARE_B, 8'h55);
	endtask

	task automatic test_default_traffic();
		run_random_events(RANDOM_ITEMS);
	endtask

	task automatic test_zero_config();
		load_config(16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		run_random_events(RANDOM_ITEMS);
	endtask

	// largest step and ceiling drive speed into saturation
	task automatic test_max_config();
		load_config(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		run_random_events(RANDOM_ITEMS);
	endtask

	task automatic test_crossed_clamp();
		load_config(16'd0, 8'd3, 8'd17, 8'd200, 8'd5, 8'd200, 8'd50, 8'd2);
		run_random_events(RANDOM_ITEMS);
	endtask

	task automatic test_random_configs();
		logic [15:0] base;
		repeat (6) begin
			base = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535)) :
				16'($urandom_range(0, 3000));
			load_config(base, 8'($urandom_range(0, 255)), 8'($urandom_range(1, 60)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)));
			run_random_events(RANDOM_ITEMS);
		end
	endtask

	// receiver stalls in stretches of differing character
	int stall_mode = 0;
	int stall_left = 0;
	int stall_phase = 0;
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(20, 200);
		end
		stall_left--;
		stall_phase++;
		case (stall_mode)
			0: res_ready <= 1'b1;
			1: res_ready <= ($urandom_range(0, 3) != 0);
			2: res_ready <= ($urandom_range(0, 3) == 0);
			default: res_ready <= (stall_phase % 5 < 2);
		endcase
	end

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		shsd_pkg::res_t want;
		if (arst_n && res_valid && res_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending", 1, 0);
			end else begin
				want = pending_results.pop_front();
				check_field("coil_pattern", res.coil_pattern, want.coil_pattern);
				check_field("coil_write", res.coil_write, want.coil_write);
				check_field("timer_period", res.timer_period, want.timer_period);
				check_field("period_write", res.period_write, want.period_write);
				check_field("pwm_compare", res.pwm_compare, want.pwm_compare);
				check_field("encoder_writeback", res.encoder_writeback,
					want.encoder_writeback);
				check_field("speed_now", res.speed_now, want.speed_now);
				check_field("direction_now", res.direction_now, want.direction_now);
				check_field("phase_now", res.phase_now, want.phase_now);
			end
		end
	end

	// test sequence
	initial begin
		reset_motor_model();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_default_traffic();
		test_zero_config();
		test_max_config();
		test_crossed_clamp();
		test_random_configs();
		drain_results();
		repeat (10) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
